// ----- design/hsp_pkg.sv -----
// ----------------------------------------------------------------------------
// hsp_pkg: shared types and constants of the handle slot pool
// Field widths, request and status codes, register map and the result word.
// ----------------------------------------------------------------------------
package hsp_pkg;

   localparam int TYPE_W         = 3;
   localparam int SLOT_W         = 8;
   localparam int PORT_DATA_W    = 32;
   localparam int STATUS_W       = 2;
   localparam int COUNT_W        = 9;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int DEF_MAX_SLOTS  = 256;
   localparam int DEF_DATA_WIDTH = 32;

   typedef enum logic [TYPE_W-1:0] {
      REQ_ADD       = 3'd0,
      REQ_READ      = 3'd1,
      REQ_UPDATE    = 3'd2,
      REQ_REMOVE    = 3'd3,
      REQ_TO_HANDLE = 3'd4
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_BAD     = 2'd2,
      ST_REFUSED = 2'd3
   } status_type;

   // register index = byte address / 4
   typedef enum logic [0:0] {
      CSR_SLOT_COUNT = 1'b0
   } csr_index_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'b01,
      FSM_EXEC = 2'b10
   } fsm_type;

   typedef struct packed {
      logic                   result_valid;
      logic [SLOT_W-1:0]      result_index;
      logic [PORT_DATA_W-1:0] read_data;
      status_type             status;
   } rsp_word_type;

endpackage

// ----- design/hsp_req_if.sv -----
// ----------------------------------------------------------------------------
// hsp_req_if: request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface hsp_req_if;
   import hsp_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [TYPE_W-1:0]      req_type;
   logic [SLOT_W-1:0]      slot_index;
   logic                   handle_valid;
   logic [PORT_DATA_W-1:0] write_data;

   modport source (
      output valid, req_type, slot_index, handle_valid, write_data,
      input  ready
   );
   modport sink (
      input  valid, req_type, slot_index, handle_valid, write_data,
      output ready
   );
endinterface

// ----- design/hsp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// hsp_rsp_if: result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface hsp_rsp_if;
   import hsp_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   result_valid;
   logic [SLOT_W-1:0]      result_index;
   logic [PORT_DATA_W-1:0] read_data;
   logic [STATUS_W-1:0]    status;

   modport source (
      output valid, result_valid, result_index, read_data, status,
      input  ready
   );
   modport sink (
      input  valid, result_valid, result_index, read_data, status,
      output ready
   );
endinterface

// ----- design/hsp_ram.sv -----
// ----------------------------------------------------------------------------
// hsp_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module hsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- design/hsp_csr.sv -----
// ----------------------------------------------------------------------------
// hsp_csr: configuration registers
// APB-style slave holding the slot count.
// ----------------------------------------------------------------------------
module hsp_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [hsp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [hsp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [hsp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output logic [hsp_pkg::COUNT_W-1:0]    slot_count
);
   import hsp_pkg::*;

   logic [COUNT_W-1:0] slot_count_ff;
   logic               wr_hit;
   logic               sel_count;

   assign pready    = 1'b1;
   assign sel_count = (paddr[CSR_ADDR_W-1:2] == CSR_SLOT_COUNT);
   assign wr_hit    = psel && penable && pwrite && pready && sel_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= '0;
      end else if (wr_hit) begin
         slot_count_ff <= pwdata[COUNT_W-1:0];
      end
   end

   assign prdata     = sel_count ? CSR_DATA_W'(slot_count_ff) : '0;
   assign slot_count = slot_count_ff;
endmodule

// ----- design/hsp_engine.sv -----
// ----------------------------------------------------------------------------
// hsp_engine: slot allocator core
// Bump head, free-slot stack and data store; read in accept cycle, modify and
// write back in the execute cycle.
// ----------------------------------------------------------------------------
module hsp_engine #(
   parameter int MAX_SLOTS  = hsp_pkg::DEF_MAX_SLOTS,
   parameter int DATA_WIDTH = hsp_pkg::DEF_DATA_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [hsp_pkg::COUNT_W-1:0] slot_count,
   hsp_req_if.sink                     req,
   output logic                        exec_valid,
   output hsp_pkg::rsp_word_type       exec_word,
   input  logic                        exec_take
);
   import hsp_pkg::*;

   localparam int AW = $clog2(MAX_SLOTS);
   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;

   fsm_type                fsm_ff, fsm_in;
   logic [CW-1:0]          head_ff, head_in;
   logic [CW-1:0]          depth_ff, depth_in;
   logic [TYPE_W-1:0]      kind_ff;
   logic [SLOT_W-1:0]      idx_ff;
   logic                   hv_ff;
   logic [PORT_DATA_W-1:0] wdata_ff;

   logic                   accept;
   logic                   fire;
   logic                   wrap;
   logic [CW-1:0]          head_eff;
   logic [CW-1:0]          depth_eff;
   logic [NW-1:0]          count_n;
   logic                   in_range;

   logic                   stk_we_c, dat_we_c;
   logic [AW-1:0]          stk_waddr, dat_waddr;
   logic [SLOT_W-1:0]      stk_rdata;
   logic [DATA_WIDTH-1:0]  dat_rdata;
   rsp_word_type           word;

   assign req.ready  = (fsm_ff == FSM_IDLE);
   assign accept     = req.valid && req.ready;
   assign exec_valid = (fsm_ff == FSM_EXEC);
   assign fire       = exec_valid && exec_take;

   // stack caught up with the head: pool empties out before an add
   assign wrap      = (depth_ff != '0) && (depth_ff >= head_ff);
   assign head_eff  = wrap ? '0 : head_ff;
   assign depth_eff = wrap ? '0 : depth_ff;

   assign count_n  = (NW'(slot_count) < NW'(MAX_SLOTS)) ? NW'(slot_count) : NW'(MAX_SLOTS);
   assign in_range = NW'(idx_ff) < count_n;

   hsp_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (MAX_SLOTS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (fire && stk_we_c),
      .wr_addr (stk_waddr),
      .wr_data (idx_ff),
      .rd_en   (accept),
      .rd_addr (AW'(depth_eff - CW'(1))),
      .rd_data (stk_rdata)
   );

   hsp_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (MAX_SLOTS)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (fire && dat_we_c),
      .wr_addr (dat_waddr),
      .wr_data (DATA_WIDTH'(wdata_ff)),
      .rd_en   (accept),
      .rd_addr (AW'(req.slot_index)),
      .rd_data (dat_rdata)
   );

   always_comb begin
      head_in           = head_ff;
      depth_in          = depth_ff;
      stk_we_c          = 1'b0;
      dat_we_c          = 1'b0;
      stk_waddr         = AW'(depth_ff);
      dat_waddr         = AW'(idx_ff);
      word.result_valid = 1'b0;
      word.result_index = idx_ff;
      word.read_data    = '0;
      word.status       = ST_OK;
      unique case (req_kind_type'(kind_ff))
         REQ_ADD: begin
            head_in  = head_eff;
            depth_in = depth_eff;
            if (depth_eff != '0) begin
               depth_in          = depth_eff - CW'(1);
               dat_waddr         = AW'(stk_rdata);
               dat_we_c          = 1'b1;
               word.result_valid = 1'b1;
               word.result_index = stk_rdata;
            end else if (NW'(head_eff) < count_n) begin
               head_in           = head_eff + CW'(1);
               dat_waddr         = AW'(head_eff);
               dat_we_c          = 1'b1;
               word.result_valid = 1'b1;
               word.result_index = SLOT_W'(head_eff);
            end else begin
               word.result_index = '0;
               word.status       = ST_FULL;
            end
         end
         REQ_READ: begin
            if (hv_ff && in_range) begin
               word.result_valid = 1'b1;
               word.read_data    = PORT_DATA_W'(dat_rdata);
            end else begin
               word.status = ST_BAD;
            end
         end
         REQ_UPDATE: begin
            if (hv_ff && in_range) begin
               word.result_valid = 1'b1;
               dat_we_c          = 1'b1;
            end else begin
               word.status = ST_BAD;
            end
         end
         REQ_REMOVE: begin
            if (!hv_ff || !in_range) begin
               word.status = ST_BAD;
            end else if (depth_ff >= head_ff) begin
               word.status = ST_REFUSED;
            end else begin
               stk_we_c          = 1'b1;
               depth_in          = depth_ff + CW'(1);
               word.result_valid = 1'b1;
            end
         end
         REQ_TO_HANDLE: begin
            if (!in_range) begin
               word.status = ST_BAD;
            end else begin
               word.result_valid = NW'(idx_ff) < NW'(head_ff);
            end
         end
         default: begin
            word.status = ST_BAD;
         end
      endcase
   end

   assign exec_word = word;

   always_comb begin
      unique case (fsm_ff)
         FSM_IDLE: fsm_in = accept ? FSM_EXEC : FSM_IDLE;
         FSM_EXEC: fsm_in = fire ? FSM_IDLE : FSM_EXEC;
         default:  fsm_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff   <= FSM_IDLE;
         head_ff  <= '0;
         depth_ff <= '0;
      end else begin
         fsm_ff <= fsm_in;
         if (fire) begin
            head_ff  <= head_in;
            depth_ff <= depth_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req.req_type;
         idx_ff   <= req.slot_index;
         hv_ff    <= req.handle_valid;
         wdata_ff <= req.write_data;
      end
   end
endmodule

// ----- design/handle_slot_pool.sv -----
// A taken request word is registered while the stack and data RAMs are read;
//   execute then writes back and loads the result word into the output register.
// No new request is taken until the previous one has left the execute stage.
// A stalled result waits in the output register; the next request is still
//   taken and held in the execute stage until the output drains.
// Reset (synchronous, active high) empties the pool and clears the slot count.
// ----------------------------------------------------------------------------
// handle_slot_pool: slot allocator with free-slot stack and data store
// Top level: configuration registers, allocator core and output register.
// ----------------------------------------------------------------------------
module handle_slot_pool #(
   parameter int MAX_SLOTS  = hsp_pkg::DEF_MAX_SLOTS,
   parameter int DATA_WIDTH = hsp_pkg::DEF_DATA_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   hsp_req_if.sink                        req_port,
   hsp_rsp_if.source                      rsp_port,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [hsp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [hsp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [hsp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import hsp_pkg::*;

   logic [COUNT_W-1:0] slot_count;
   logic               exec_valid;
   logic               exec_take;
   rsp_word_type       exec_word;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_word_ff;

   // register file: slot count only
   hsp_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .slot_count (slot_count)
   );

   // allocator core: owns head, stack depth and both RAMs
   hsp_engine #(
      .MAX_SLOTS  (MAX_SLOTS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .slot_count (slot_count),
      .req        (req_port),
      .exec_valid (exec_valid),
      .exec_word  (exec_word),
      .exec_take  (exec_take)
   );

   // The core may retire only into an empty register, or one being drained now.
   assign exec_take = !rsp_valid_ff || rsp_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_valid && exec_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         // drop the word once taken
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload: load on retire, hold otherwise
   always_ff @(posedge clock) begin
      if (exec_valid && exec_take) begin
         rsp_word_ff <= exec_word;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.result_valid = rsp_word_ff.result_valid;
   assign rsp_port.result_index = rsp_word_ff.result_index;
   assign rsp_port.read_data    = rsp_word_ff.read_data;
   assign rsp_port.status       = rsp_word_ff.status;
endmodule

// ----- design/hsp_checker.sv -----
// ----------------------------------------------------------------------------
// hsp_checker: port-level checks of the handle slot pool
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
module hsp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           result_valid,
   input logic [hsp_pkg::SLOT_W-1:0]     result_index,
   input logic [hsp_pkg::PORT_DATA_W-1:0] read_data,
   input logic [hsp_pkg::STATUS_W-1:0]   status,
   input logic                           psel,
   input logic                           penable,
   input logic                           pwrite,
   input logic [hsp_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [hsp_pkg::CSR_DATA_W-1:0] pwdata,
   input logic [hsp_pkg::CSR_DATA_W-1:0] prdata,
   input logic                           pready
);
   import hsp_pkg::*;

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_valid)
         && $stable(result_index) && $stable(read_data) && $stable(status))
      else $error("result word changed while stalled");

   // one request in flight: no request taken in the execute cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one executes");

   // a fresh result follows a taken request that has passed the execute state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result word without a matching request");

   // slot count reads back what was written
   assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready && (paddr[CSR_ADDR_W-1:2] == CSR_SLOT_COUNT)
         ##1 (paddr[CSR_ADDR_W-1:2] == CSR_SLOT_COUNT)
      |-> prdata[COUNT_W-1:0] == $past(pwdata[COUNT_W-1:0]))
      else $error("slot count readback mismatch");
endmodule

bind handle_slot_pool hsp_checker u_hsp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_port.valid),
   .req_ready    (req_port.ready),
   .rsp_valid    (rsp_port.valid),
   .rsp_ready    (rsp_port.ready),
   .result_valid (rsp_port.result_valid),
   .result_index (rsp_port.result_index),
   .read_data    (rsp_port.read_data),
   .status       (rsp_port.status),
   .psel         (psel),
   .penable      (penable),
   .pwrite       (pwrite),
   .paddr        (paddr),
   .pwdata       (pwdata),
   .prdata       (prdata),
   .pready       (pready)
);

// ----- tb/tb_handle_slot_pool.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_handle_slot_pool: self-checking bench for the handle slot pool
// A short table of directed requests, then random phases under several slot
// counts. Every accepted request word is answered by a behavioural copy of the
// pool (bump head, free stack, data store); result words are checked in order,
// field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_handle_slot_pool;
   import hsp_pkg::*;

   // request codes the pool does not know
   localparam logic [TYPE_W-1:0] REQ_UNKNOWN_LO = 3'd5;
   localparam logic [TYPE_W-1:0] REQ_UNKNOWN_HI = 3'd7;
   localparam int                NUM_SLOTS      = DEF_MAX_SLOTS;
   localparam int                PHASE_ITEMS    = 55;
   localparam int                PRINT_CAP      = 200;
   localparam rsp_word_type      NO_WORD        = '0;

   // one row of the directed table: a slot count write or a request word,
   // the latter optionally with its answer typed in
   typedef struct {
      bit                     is_cfg;
      logic [COUNT_W-1:0]     cfg_val;
      logic [TYPE_W-1:0]      kind;
      logic [SLOT_W-1:0]      idx;
      logic                   hv;
      logic [PORT_DATA_W-1:0] wd;
      bit                     pinned;
      rsp_word_type           want;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   hsp_req_if req_ch ();
   hsp_rsp_if rsp_ch ();

   handle_slot_pool dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // behavioural copy of the pool
   logic [COUNT_W-1:0]     pool_count;
   logic [COUNT_W-1:0]     pool_head;
   logic [COUNT_W-1:0]     pool_depth;
   logic [SLOT_W-1:0]      pool_stack   [NUM_SLOTS];
   logic [PORT_DATA_W-1:0] pool_data    [NUM_SLOTS];
   bit                     pool_written [NUM_SLOTS];

   // slots handed out and not yet handed back: targets for well-formed traffic
   logic [SLOT_W-1:0]      live_slots [$];
   // answers owed by the pool, oldest first
   rsp_word_type           due_results [$];

   plan_row_type           plan_rows [$];
   int                     plan_counts [10] = '{4, 1, 256, 0, 3, 511, 16, 2, 256, 40};
   int                     fail_count;
   bit                     pin_on;
   rsp_word_type           pin_want;
   bit                     source_gaps;
   bit                     sink_stalls;
   int                     stall_left;

   // 4 ns clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   task automatic report(input string what);
      fail_count++;
      if (fail_count <= PRINT_CAP) begin
         $display("%0d ns: mismatch: %s", $time, what);
      end
   endtask

   // slot count as the pool uses it: never more than the slots built
   function automatic logic [COUNT_W-1:0] pool_limit();
      return (pool_count > NUM_SLOTS) ? COUNT_W'(NUM_SLOTS) : pool_count;
   endfunction

   // work out the answer to one request word and advance the pool copy
   function automatic rsp_word_type pool_answer(input logic [TYPE_W-1:0]      kind,
                                                input logic [SLOT_W-1:0]      idx,
                                                input logic                   hv,
                                                input logic [PORT_DATA_W-1:0] wd);
      rsp_word_type       ans;
      logic [COUNT_W-1:0] limit;
      bit                 in_range;
      bit                 got;
      logic [SLOT_W-1:0]  slot;
      limit                = pool_limit();
      in_range             = {1'b0, idx} < limit;
      ans.result_valid     = 1'b0;
      ans.result_index     = idx;
      ans.read_data        = '0;
      ans.status           = ST_OK;
      got                  = 1'b0;
      slot                 = '0;
      case (kind)
         REQ_ADD: begin
            // a stack that has caught up with the head holds every slot: start over
            if (pool_depth != 0 && pool_depth >= pool_head) begin
               pool_head  = '0;
               pool_depth = '0;
            end
            if (pool_depth != 0) begin
               // pop a freed slot as it is, even past a shrunk count
               pool_depth = pool_depth - 1'b1;
               slot       = pool_stack[pool_depth];
               got        = 1'b1;
            end else if (pool_head < limit) begin
               slot      = pool_head[SLOT_W-1:0];
               pool_head = pool_head + 1'b1;
               got       = 1'b1;
            end
            if (got) begin
               pool_data[slot]    = wd;
               pool_written[slot] = 1'b1;
               ans.result_valid   = 1'b1;
               ans.result_index   = slot;
            end else begin
               ans.result_index = '0;
               ans.status       = ST_FULL;
            end
         end
         REQ_READ: begin
            if (hv && in_range) begin
               ans.result_valid = 1'b1;
               ans.read_data    = pool_data[idx];
            end else begin
               ans.status = ST_BAD;
            end
         end
         REQ_UPDATE: begin
            if (hv && in_range) begin
               ans.result_valid  = 1'b1;
               pool_data[idx]    = wd;
               pool_written[idx] = 1'b1;
            end else begin
               ans.status = ST_BAD;
            end
         end
         REQ_REMOVE: begin
            if (!hv || !in_range) begin
               ans.status = ST_BAD;
            end else if (pool_depth >= pool_head || pool_depth >= NUM_SLOTS) begin
               ans.status = ST_REFUSED;
            end else begin
               pool_stack[pool_depth] = idx;
               pool_depth             = pool_depth + 1'b1;
               ans.result_valid       = 1'b1;
            end
         end
         REQ_TO_HANDLE: begin
            // the handle flag plays no part here
            if (!in_range) begin
               ans.status = ST_BAD;
            end else if ({1'b0, idx} < pool_head) begin
               ans.result_valid = 1'b1;
            end
         end
         default: begin
            ans.status = ST_BAD;
         end
      endcase
      return ans;
   endfunction

   // Watch both channels at the rising edge: predict on every request word taken,
   // check every result word taken against the oldest answer owed.
   always @(posedge clock) begin : watch
      rsp_word_type want_word;
      if (!reset && req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
         want_word = pool_answer(req_ch.req_type, req_ch.slot_index,
                                 req_ch.handle_valid, req_ch.write_data);
         // keep the list of live slots in step with the pool
         if (want_word.result_valid && req_ch.req_type == REQ_ADD) begin
            live_slots.push_back(want_word.result_index);
         end else if (want_word.result_valid && req_ch.req_type == REQ_REMOVE) begin
            for (int k = 0; k < live_slots.size(); k++) begin
               if (live_slots[k] == req_ch.slot_index) begin
                  live_slots.delete(k);
                  break;
               end
            end
         end
         // a directed row with its answer typed in is held to that answer
         if (pin_on) begin
            want_word = pin_want;
         end
         due_results.push_back(want_word);
      end
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (due_results.size() == 0) begin
            report($sformatf("result word with nothing outstanding: valid %b index %h",
                             rsp_ch.result_valid, rsp_ch.result_index));
         end else begin
            want_word = due_results.pop_front();
            if (rsp_ch.result_valid !== want_word.result_valid) begin
               report($sformatf("result_valid got %b want %b",
                                rsp_ch.result_valid, want_word.result_valid));
            end
            if (rsp_ch.result_index !== want_word.result_index) begin
               report($sformatf("result_index got %h want %h",
                                rsp_ch.result_index, want_word.result_index));
            end
            if (rsp_ch.read_data !== want_word.read_data) begin
               report($sformatf("read_data got %h want %h",
                                rsp_ch.read_data, want_word.read_data));
            end
            if (rsp_ch.status !== want_word.status) begin
               report($sformatf("status got %0d want %0d",
                                rsp_ch.status, want_word.status));
            end
         end
      end
   end

   // Result side: stall at random, mostly briefly, now and then for a long spell.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (sink_stalls && $urandom_range(0, 99) < 25) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(0, 2);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // idle cycles after a request word: mostly none or a few, rarely many
   function automatic int pick_gap();
      int roll;
      if (!source_gaps) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 25);
   endfunction

   // Offer one request word from the falling edge until it is taken, then idle.
   // Valid stays high straight into the next word unless there is a gap or this
   // is the last word before a pause.
   task automatic put_word(input logic [TYPE_W-1:0]      kind,
                           input logic [SLOT_W-1:0]      idx,
                           input logic                   hv,
                           input logic [PORT_DATA_W-1:0] wd,
                           input bit                     pinned,
                           input rsp_word_type           want,
                           input bit                     last);
      int gap;
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= kind;
      req_ch.slot_index   <= idx;
      req_ch.handle_valid <= hv;
      req_ch.write_data   <= wd;
      pin_on              <= pinned;
      pin_want            <= want;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
      gap = pick_gap();
      if (gap != 0 || last) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // wait until every answer owed has come back
   task automatic drain();
      while (due_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Write the slot count over the register port while the pool is idle,
   // then read it back.
   task automatic set_slot_count(input logic [COUNT_W-1:0] value);
      drain();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {CSR_SLOT_COUNT, 2'b00};
      pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      pool_count = value;
      @(negedge clock);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== CSR_DATA_W'(value)) begin
         report($sformatf("slot_count read back %h want %h", prdata, value));
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Draw one random request word. Most words name a live slot so that reads,
   // updates and removes get past the checks; the rest is noise.
   task automatic draw_item(output logic [TYPE_W-1:0]      kind,
                            output logic [SLOT_W-1:0]      idx,
                            output logic                   hv,
                            output logic [PORT_DATA_W-1:0] wd);
      int roll;
      int limit;
      limit = pool_limit();
      roll  = $urandom_range(0, 99);
      if (roll < 32) begin
         kind = REQ_ADD;
      end else if (roll < 52) begin
         kind = REQ_READ;
      end else if (roll < 64) begin
         kind = REQ_UPDATE;
      end else if (roll < 82) begin
         kind = REQ_REMOVE;
      end else if (roll < 94) begin
         kind = REQ_TO_HANDLE;
      end else begin
         kind = TYPE_W'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
      end
      hv   = ($urandom_range(0, 9) != 0);
      roll = $urandom_range(0, 99);
      if (live_slots.size() != 0 && roll < 70) begin
         idx = live_slots[$urandom_range(0, live_slots.size() - 1)];
      end else if (limit != 0 && roll < 85) begin
         idx = SLOT_W'($urandom_range(0, limit - 1));
      end else begin
         idx = SLOT_W'($urandom());
      end
      roll = $urandom_range(0, 9);
      wd   = (roll == 0) ? '1 : (roll == 1) ? '0 : $urandom();
      // never read an entry the pool has not stored yet: null the handle instead
      if (kind == REQ_READ && hv && idx < limit && !pool_written[idx]) begin
         hv = 1'b0;
      end
   endtask

   function automatic void plan_item(input logic [TYPE_W-1:0]      kind,
                                     input logic [SLOT_W-1:0]      idx,
                                     input logic                   hv,
                                     input logic [PORT_DATA_W-1:0] wd,
                                     input bit                     pinned,
                                     input logic                   rv,
                                     input logic [SLOT_W-1:0]      ridx,
                                     input logic [PORT_DATA_W-1:0] rd,
                                     input status_type             st);
      plan_row_type row;
      row.is_cfg            = 1'b0;
      row.cfg_val           = '0;
      row.kind              = kind;
      row.idx               = idx;
      row.hv                = hv;
      row.wd                = wd;
      row.pinned            = pinned;
      row.want.result_valid = rv;
      row.want.result_index = ridx;
      row.want.read_data    = rd;
      row.want.status       = st;
      plan_rows.push_back(row);
   endfunction

   function automatic void plan_cfg(input logic [COUNT_W-1:0] value);
      plan_row_type row;
      row        = '{default: '0};
      row.is_cfg = 1'b1;
      row.cfg_val = value;
      plan_rows.push_back(row);
   endfunction

   // Time limit: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("tb_handle_slot_pool NOT OK");
      $finish;
   end

   initial begin : stimulus
      logic [TYPE_W-1:0]      kind;
      logic [SLOT_W-1:0]      idx;
      logic                   hv;
      logic [PORT_DATA_W-1:0] wd;

      // every input known from the start; pool copy as after reset
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.req_type     = REQ_ADD;
      req_ch.slot_index   = '0;
      req_ch.handle_valid = 1'b0;
      req_ch.write_data   = '0;
      rsp_ch.ready        = 1'b0;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      pool_count          = '0;
      pool_head           = '0;
      pool_depth          = '0;
      fail_count          = 0;
      pin_on              = 1'b0;
      pin_want            = NO_WORD;
      source_gaps         = 1'b1;
      sink_stalls         = 1'b1;

      // Directed table. After reset the count is zero: adds find the pool full,
      // every index is out of range, and unknown codes are answered as bad.
      plan_item(REQ_ADD,        8'h00, 1'b0, 32'h0000_0000, 1, 1'b0, 8'h00, 32'h0, ST_FULL);
      plan_item(REQ_READ,       8'h00, 1'b1, 32'h0000_0000, 1, 1'b0, 8'h00, 32'h0, ST_BAD);
      plan_item(REQ_TO_HANDLE,  8'hFF, 1'b0, 32'h0000_0000, 1, 1'b0, 8'hFF, 32'h0, ST_BAD);
      plan_item(REQ_UNKNOWN_LO, 8'h5A, 1'b1, 32'hFFFF_FFFF, 1, 1'b0, 8'h5A, 32'h0, ST_BAD);
      // full size: bump the head, read, update, null handles
      plan_cfg(9'd256);
      plan_item(REQ_ADD,    8'h00, 1'b0, 32'hFFFF_FFFF, 1, 1'b1, 8'h00, 32'h0, ST_OK);
      plan_item(REQ_ADD,    8'h00, 1'b0, 32'h0000_0000, 1, 1'b1, 8'h01, 32'h0, ST_OK);
      plan_item(REQ_ADD,    8'h00, 1'b0, 32'hA5A5_A5A5, 1, 1'b1, 8'h02, 32'h0, ST_OK);
      plan_item(REQ_READ,   8'h00, 1'b1, 32'h0000_0000, 1, 1'b1, 8'h00, 32'hFFFF_FFFF, ST_OK);
      plan_item(REQ_READ,   8'h01, 1'b0, 32'h0000_0000, 1, 1'b0, 8'h01, 32'h0, ST_BAD);
      plan_item(REQ_UPDATE, 8'h02, 1'b1, 32'h5A5A_5A5A, 1, 1'b1, 8'h02, 32'h0, ST_OK);
      plan_item(REQ_READ,   8'h02, 1'b1, 32'h0000_0000, 1, 1'b1, 8'h02, 32'h5A5A_5A5A, ST_OK);
      // to-handle ignores the handle flag; in range but past the head is not live
      plan_item(REQ_TO_HANDLE, 8'h02, 1'b0, 32'h0, 1, 1'b1, 8'h02, 32'h0, ST_OK);
      plan_item(REQ_TO_HANDLE, 8'h03, 1'b1, 32'h0, 1, 1'b0, 8'h03, 32'h0, ST_OK);
      // hand back every slot, then one too many: refused
      plan_item(REQ_REMOVE, 8'h01, 1'b0, 32'h0, 1, 1'b0, 8'h01, 32'h0, ST_BAD);
      plan_item(REQ_REMOVE, 8'h01, 1'b1, 32'h0, 1, 1'b1, 8'h01, 32'h0, ST_OK);
      plan_item(REQ_REMOVE, 8'h00, 1'b1, 32'h0, 1, 1'b1, 8'h00, 32'h0, ST_OK);
      plan_item(REQ_REMOVE, 8'h02, 1'b1, 32'h0, 1, 1'b1, 8'h02, 32'h0, ST_OK);
      plan_item(REQ_REMOVE, 8'h02, 1'b1, 32'h0, 1, 1'b0, 8'h02, 32'h0, ST_REFUSED);
      // stack level with the head: the next add starts the pool over at slot zero
      plan_item(REQ_ADD, 8'h00, 1'b0, 32'h0000_0001, 1, 1'b1, 8'h00, 32'h0, ST_OK);
      plan_item(REQ_ADD, 8'h00, 1'b0, 32'h1234_5678, 0, 1'b0, 8'h00, 32'h0, ST_OK);
      plan_item(REQ_REMOVE, 8'hFF, 1'b1, 32'h0, 0, 1'b0, 8'h00, 32'h0, ST_OK);
      // shrink the count: the freed top slot is still popped as it is
      plan_cfg(9'd2);
      plan_item(REQ_ADD,       8'h00, 1'b0, 32'hC3C3_C3C3, 0, 1'b0, 8'h00, 32'h0, ST_OK);
      plan_item(REQ_READ,      8'hFF, 1'b1, 32'h0, 1, 1'b0, 8'hFF, 32'h0, ST_BAD);
      plan_item(REQ_TO_HANDLE, 8'h01, 1'b0, 32'h0, 1, 1'b1, 8'h01, 32'h0, ST_OK);
      plan_item(REQ_ADD,       8'h00, 1'b0, 32'h0, 1, 1'b0, 8'h00, 32'h0, ST_FULL);

      // hold reset at the start, then release it for good
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int r = 0; r < plan_rows.size(); r++) begin
         if (plan_rows[r].is_cfg) begin
            set_slot_count(plan_rows[r].cfg_val);
         end else begin
            put_word(plan_rows[r].kind, plan_rows[r].idx, plan_rows[r].hv, plan_rows[r].wd,
                     plan_rows[r].pinned, plan_rows[r].want,
                     (r + 1 == plan_rows.size()) || plan_rows[r + 1].is_cfg);
         end
      end

      // Random phases, one slot count each; some phases run without gaps on the
      // request side, some without stalls on the result side.
      for (int ph = 0; ph < 10; ph++) begin
         source_gaps = (ph % 3 != 1);
         sink_stalls <= (ph % 4 != 2);
         set_slot_count(COUNT_W'(plan_counts[ph]));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            draw_item(kind, idx, hv, wd);
            put_word(kind, idx, hv, wd, 1'b0, NO_WORD, n == PHASE_ITEMS - 1);
         end
      end

      // let the last answers drain, then a few quiet cycles
      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_handle_slot_pool OK");
      end else begin
         $display("tb_handle_slot_pool NOT OK");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/hsp_pkg.sv
design/hsp_req_if.sv
design/hsp_rsp_if.sv
design/hsp_ram.sv
design/hsp_csr.sv
design/hsp_engine.sv
design/handle_slot_pool.sv
design/hsp_checker.sv
tb/tb_handle_slot_pool.sv
